[src/ahs_pkg.sv]
// Shared types, codes and helpers of the three-axis homing sequencer.
// No dependencies; every other file imports this package.
package ahs_pkg;

  localparam int NUM_AXES   = 3;
  localparam int AXIS_W     = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
  localparam int SPEED_REGS = 3;
  localparam int SPEED_W    = 11;
  localparam int BACKOFF_W  = 16;
  localparam int POS_W      = 24;
  localparam int VEL_W      = 12;
  localparam int STEP_W     = 3;
  localparam int MASK_W     = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [BACKOFF_W-1:0] BACKOFF_RESET = 16'd1000;

  // Homing steps
  localparam logic [STEP_W-1:0] STEP_IDLE    = 3'd0;
  localparam logic [STEP_W-1:0] STEP_ARMED   = 3'd1;
  localparam logic [STEP_W-1:0] STEP_SEARCH  = 3'd2;
  localparam logic [STEP_W-1:0] STEP_BACKOFF = 3'd3;
  localparam logic [STEP_W-1:0] STEP_SLOW    = 3'd4;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FAST0   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FAST1   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FAST2   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SLOW0   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SLOW1   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SLOW2   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BACKOFF = 3'd6;

  typedef enum logic [1:0] {
    ACT_POLL      = 2'd0,
    ACT_START_ONE = 2'd1,
    ACT_START_ALL = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    MODE_LEFT       = 2'd0,
    MODE_RIGHT      = 2'd1,
    MODE_LEFT_HOME  = 2'd2,
    MODE_RIGHT_HOME = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    RAMP_NONE     = 2'd0,
    RAMP_VELOCITY = 2'd1,
    RAMP_POSITION = 2'd2
  } ramp_e;

  typedef enum logic [1:0] {
    VMAX_NONE   = 2'd0,
    VMAX_FULL   = 2'd1,
    VMAX_NORMAL = 2'd2
  } vmax_e;

  typedef struct packed {
    logic                    accel;
    ramp_e                   ramp;
    vmax_e                   vmax;
    logic                    vt_write;
    logic signed [VEL_W-1:0] vt_value;
    logic                    xt_write;
    logic signed [POS_W-1:0] xt_value;
    logic                    zero;
  } cmd_t;

  localparam cmd_t CMD_NONE = '{
    accel: 1'b0, ramp: RAMP_NONE, vmax: VMAX_NONE, vt_write: 1'b0,
    vt_value: '0, xt_write: 1'b0, xt_value: '0, zero: 1'b0
  };

  // Speed magnitude to signed velocity; left is negative.
  function automatic logic signed [VEL_W-1:0] vel12(logic [SPEED_W-1:0] mag,
                                                    logic left);
    logic [VEL_W-1:0] m;
    m = {1'b0, mag};
    return left ? $signed(12'd0 - m) : $signed(m);
  endfunction

endpackage

[src/ahs_axis_step.sv]
// One homing step of the addressed axis: next step, homed set and ramp commands.
// Depends on ahs_pkg.
module ahs_axis_step (
  input  logic [ahs_pkg::STEP_W-1:0]    step_i,
  input  logic [1:0]                    mode_i,
  input  logic                          left_limit_i,
  input  logic                          right_limit_i,
  input  logic                          target_reached_i,
  input  logic                          home_sensor_i,
  input  logic [ahs_pkg::POS_W-1:0]     actual_i,
  input  logic [ahs_pkg::SPEED_W-1:0]   fast_speed_i,
  input  logic [ahs_pkg::SPEED_W-1:0]   slow_speed_i,
  input  logic [ahs_pkg::BACKOFF_W-1:0] backoff_i,
  output logic [ahs_pkg::STEP_W-1:0]    step_o,
  output logic                          set_homed_o,
  output ahs_pkg::cmd_t                 cmd_o
);
  import ahs_pkg::*;

  mode_e mode;
  logic  left_mode;
  logic  limit_mode;
  logic  sw;
  logic  touched;
  logic [POS_W-1:0] back_ext;

  assign mode       = mode_e'(mode_i);
  assign left_mode  = (mode == MODE_LEFT) || (mode == MODE_LEFT_HOME);
  assign limit_mode = (mode == MODE_LEFT) || (mode == MODE_RIGHT);
  assign sw         = left_mode ? left_limit_i : right_limit_i;
  assign touched    = !home_sensor_i;
  assign back_ext   = {{(POS_W-BACKOFF_W){1'b0}}, backoff_i};

  always_comb begin
    step_o      = step_i;
    set_homed_o = 1'b0;
    cmd_o       = CMD_NONE;
    case (step_i)
      STEP_ARMED: begin
        cmd_o.accel    = 1'b1;
        cmd_o.ramp     = RAMP_VELOCITY;
        cmd_o.vmax     = VMAX_FULL;
        cmd_o.vt_write = 1'b1;
        cmd_o.vt_value = vel12(fast_speed_i, left_mode);
        step_o         = STEP_SEARCH;
      end
      STEP_SEARCH: begin
        if (sw) begin
          if (limit_mode) begin
            // back off away from the switch in position mode
            cmd_o.accel    = 1'b1;
            cmd_o.ramp     = RAMP_POSITION;
            cmd_o.vmax     = VMAX_NORMAL;
            cmd_o.xt_write = 1'b1;
            cmd_o.xt_value = $signed(left_mode ? actual_i + back_ext
                                               : actual_i - back_ext);
          end else begin
            cmd_o.vt_write = 1'b1;
            cmd_o.vt_value = vel12(slow_speed_i, !left_mode);
          end
          step_o = STEP_BACKOFF;
        end
      end
      STEP_BACKOFF: begin
        if (limit_mode) begin
          if (target_reached_i) begin
            cmd_o.accel    = 1'b1;
            cmd_o.ramp     = RAMP_VELOCITY;
            cmd_o.vmax     = VMAX_FULL;
            cmd_o.vt_write = 1'b1;
            cmd_o.vt_value = vel12(slow_speed_i, left_mode);
            step_o         = STEP_SLOW;
          end
        end else if (touched) begin
          cmd_o.zero  = 1'b1;
          set_homed_o = 1'b1;
          step_o      = STEP_IDLE;
        end
      end
      STEP_SLOW: begin
        if (limit_mode && sw) begin
          cmd_o.zero  = 1'b1;
          set_homed_o = 1'b1;
          step_o      = STEP_IDLE;
        end
      end
      default: begin
        step_o = step_i;
      end
    endcase
  end

endmodule

[src/axis_homing_sequencer.sv]
// Top level of the three-axis homing sequencer: config registers, axis state,
// result register. Depends on ahs_pkg and ahs_axis_step.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------
//  in      | sink      | in_valid_i / in_stall_o | action .. actual_position
//  out     | source    | out_valid_o / out_stall_i| accel_write .. param_error
//  cfg     | sink      | cfg_we_i               | cfg_index_i, cfg_data_i
//
// The step logic sits between the axis state and the result register, so a new
// beat is taken every cycle unless the result register is full and stalled.
// An input beat is held off only while the result register is full and stalled.
// Reset clears the axis steps, homed flags and output valid and loads register reset values.
module axis_homing_sequencer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ahs_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ahs_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     action_i,
  input  logic [1:0]                     axis_i,
  input  logic [1:0]                     search_mode_i,
  input  logic                           left_limit_i,
  input  logic                           right_limit_i,
  input  logic                           target_reached_i,
  input  logic                           home_sensor_i,
  input  logic signed [23:0]             actual_position_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           accel_write_o,
  output logic [1:0]                     ramp_mode_cmd_o,
  output logic [1:0]                     vmax_cmd_o,
  output logic                           vtarget_write_o,
  output logic signed [11:0]             vtarget_value_o,
  output logic                           xtarget_write_o,
  output logic signed [23:0]             xtarget_value_o,
  output logic                           zero_axis_o,
  output logic [2:0]                     homed_mask_o,
  output logic [2:0]                     step_now_o,
  output logic                           param_error_o
);
  import ahs_pkg::*;

  logic [SPEED_W-1:0]   fast_q [SPEED_REGS];
  logic [SPEED_W-1:0]   slow_q [SPEED_REGS];
  logic [BACKOFF_W-1:0] backoff_q;

  logic [STEP_W-1:0]    step_q [NUM_AXES];
  logic [STEP_W-1:0]    step_d [NUM_AXES];
  logic [NUM_AXES-1:0]  homed_q, homed_d;

  logic                 out_valid_q;
  cmd_t                 cmd_q, cmd_d;
  logic [MASK_W-1:0]    mask_q, mask_d;
  logic [STEP_W-1:0]    step_now_q, step_now_d;
  logic                 perr_q, perr_d;

  logic                 in_accept;
  logic                 axis_ok;
  logic [AXIS_W-1:0]    ax;
  logic [SPEED_W-1:0]   fast_sel, slow_sel;
  logic [STEP_W-1:0]    fsm_step;
  logic                 fsm_homed;
  cmd_t                 fsm_cmd;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign axis_ok    = (axis_i < NUM_AXES);
  assign ax         = axis_i[AXIS_W-1:0];
  assign fast_sel   = (axis_i < SPEED_REGS) ? fast_q[axis_i[1:0]] : '0;
  assign slow_sel   = (axis_i < SPEED_REGS) ? slow_q[axis_i[1:0]] : '0;

  ahs_axis_step u_step (
    .step_i           (axis_ok ? step_q[ax] : STEP_IDLE),
    .mode_i           (search_mode_i),
    .left_limit_i     (left_limit_i),
    .right_limit_i    (right_limit_i),
    .target_reached_i (target_reached_i),
    .home_sensor_i    (home_sensor_i),
    .actual_i         (actual_position_i),
    .fast_speed_i     (fast_sel),
    .slow_speed_i     (slow_sel),
    .backoff_i        (backoff_q),
    .step_o           (fsm_step),
    .set_homed_o      (fsm_homed),
    .cmd_o            (fsm_cmd)
  );

  always_comb begin
    step_d  = step_q;
    homed_d = homed_q;
    cmd_d   = CMD_NONE;
    perr_d  = 1'b0;
    case (action_e'(action_i))
      ACT_START_ONE: begin
        if (axis_ok) step_d[ax] = STEP_ARMED;
        else perr_d = 1'b1;
      end
      ACT_START_ALL: begin
        for (int i = 0; i < NUM_AXES; i++) step_d[i] = STEP_ARMED;
      end
      ACT_POLL: begin
        if (axis_ok) begin
          step_d[ax] = fsm_step;
          if (fsm_homed) homed_d[ax] = 1'b1;
          cmd_d = fsm_cmd;
        end
      end
      default: begin
        perr_d = 1'b0;
      end
    endcase
    step_now_d = axis_ok ? step_d[ax] : STEP_IDLE;
    mask_d = '0;
    for (int i = 0; i < NUM_AXES && i < MASK_W; i++) mask_d[i] = homed_d[i];
  end

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SPEED_REGS; i++) begin
        fast_q[i] <= '0;
        slow_q[i] <= '0;
      end
      backoff_q <= BACKOFF_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_FAST0:   fast_q[0] <= cfg_data_i[SPEED_W-1:0];
        REG_FAST1:   fast_q[1] <= cfg_data_i[SPEED_W-1:0];
        REG_FAST2:   fast_q[2] <= cfg_data_i[SPEED_W-1:0];
        REG_SLOW0:   slow_q[0] <= cfg_data_i[SPEED_W-1:0];
        REG_SLOW1:   slow_q[1] <= cfg_data_i[SPEED_W-1:0];
        REG_SLOW2:   slow_q[2] <= cfg_data_i[SPEED_W-1:0];
        REG_BACKOFF: backoff_q <= cfg_data_i[BACKOFF_W-1:0];
        default:     backoff_q <= backoff_q;
      endcase
    end
  end

  // axis state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_AXES; i++) step_q[i] <= STEP_IDLE;
      homed_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        step_q  <= step_d;
        homed_q <= homed_d;
      end
      if (in_accept) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // result payload: load on accept, hold otherwise
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cmd_q      <= cmd_d;
      mask_q     <= mask_d;
      step_now_q <= step_now_d;
      perr_q     <= perr_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign accel_write_o   = cmd_q.accel;
  assign ramp_mode_cmd_o = cmd_q.ramp;
  assign vmax_cmd_o      = cmd_q.vmax;
  assign vtarget_write_o = cmd_q.vt_write;
  assign vtarget_value_o = cmd_q.vt_value;
  assign xtarget_write_o = cmd_q.xt_write;
  assign xtarget_value_o = cmd_q.xt_value;
  assign zero_axis_o     = cmd_q.zero;
  assign homed_mask_o    = mask_q;
  assign step_now_o      = step_now_q;
  assign param_error_o   = perr_q;

endmodule

[src/ahs_checker.sv]
// Port-level checks of the homing sequencer, bound to its top level.
// Depends on ahs_pkg and axis_homing_sequencer.
module ahs_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic                           accel_write_o,
  input logic                           vtarget_write_o,
  input logic                           xtarget_write_o,
  input logic signed [23:0]             xtarget_value_o,
  input logic                           zero_axis_o,
  input logic [2:0]                     homed_mask_o,
  input logic [2:0]                     step_now_o,
  input logic                           param_error_o
);
  import ahs_pkg::*;

  // a held result beat stays until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(xtarget_value_o))
    else $error("result beat dropped or changed while stalled");

  // an empty result register never holds off input
  a_no_stall_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty result register");

  // every accepted beat shows a result in the next cycle
  a_beat_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("accepted beat produced no result");

  // a parameter error carries no command
  a_perr_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && param_error_o |-> !accel_write_o && !vtarget_write_o &&
      !xtarget_write_o && !zero_axis_o && step_now_o == STEP_IDLE)
    else $error("command issued with parameter error");

  // zeroing the axis ends the sequence with a homed axis
  a_zero_homed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zero_axis_o |-> homed_mask_o != 3'd0 && step_now_o == STEP_IDLE)
    else $error("axis zeroed without homed flag");

endmodule

bind axis_homing_sequencer ahs_checker u_ahs_checker (.*);
